@@ design/pisd_pkg.sv @@
// Package for the PWM input setpoint decoder: transaction structs, codes,
// widths and step counts of the bit-serial map datapath.
// Used by every module in the design folder.
package pisd_pkg;

    // Input event codes
    localparam logic [1:0] KIND_RISE   = 2'd0;
    localparam logic [1:0] KIND_FALL   = 2'd1;
    localparam logic [1:0] KIND_PERIOD = 2'd2;

    // Target kinds that take the direction pin
    localparam logic [1:0] TGT_SPEED   = 2'd1;
    localparam logic [1:0] TGT_CURRENT = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KIND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_AT_WIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_AT_NARROW = 3'd4;

    // Width check constants
    localparam logic [15:0] WIDTH_MARGIN = 16'd100;
    localparam logic [16:0] FULL_WIDTH   = 17'd65535;
    localparam logic [15:0] WIDE_GUARD   = 16'd65435;

    // Map datapath widths: |diff| * t < 2**48, quotient <= |diff| <= 2**32
    localparam int CNT_DATA_W = 16;
    localparam int HW_W       = 17;
    localparam int DIFF_W     = 33;
    localparam int PROD_W     = 48;
    localparam int QUO_W      = 33;

    // Serial step counts, one bit per cycle
    localparam int MUL_STEPS = CNT_DATA_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int MUL_CW    = $clog2(MUL_STEPS);
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] capture_count;
        logic        pulse_level;
        logic        dir_level;
    } t_in;

    typedef struct packed {
        logic               drive_disable;
        logic               goal_updated;
        logic signed [31:0] goal_value;
    } t_out;

    // Period-end job handed from the tracker to the map sequencer
    typedef struct packed {
        logic            confirmed;
        logic [HW_W-1:0] width;
        logic            dir_level;
    } t_job;

endpackage

@@ design/pisd_track.sv @@
// Edge tracker: seen flags, stored high time and the two-period good check.
// Registers one job per period-end transaction. Depends on pisd_pkg.
module pisd_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  pisd_pkg::t_in   i_in,
    input  logic [15:0]     i_wide,
    input  logic [15:0]     i_narrow,
    output pisd_pkg::t_job  o_job
);
    import pisd_pkg::*;

    logic [HW_W-1:0] r_high_width, n_high_width;
    logic            r_rise, n_rise;
    logic            r_fall, n_fall;
    logic            r_good_once, n_good_once;
    logic            r_good_conf, n_good_conf;
    t_job            r_job, n_job;

    logic            whole;
    logic [HW_W-1:0] width;
    logic            too_wide;
    logic            too_narrow;
    logic            good;

    // Check the period that just ended
    always_comb begin
        whole      = !r_rise && !r_fall;
        width      = whole ? (i_in.pulse_level ? FULL_WIDTH : '0) : r_high_width;
        too_wide   = (i_wide < WIDE_GUARD) &&
                     ((HW_W'(i_wide) + HW_W'(WIDTH_MARGIN)) < width);
        too_narrow = (i_narrow > WIDTH_MARGIN) &&
                     (HW_W'(i_narrow - WIDTH_MARGIN) > width);
        good       = !whole && !too_wide && !too_narrow;
    end

    // Advance flags on each accepted event
    always_comb begin
        n_high_width = r_high_width;
        n_rise       = r_rise;
        n_fall       = r_fall;
        n_good_once  = r_good_once;
        n_good_conf  = r_good_conf;
        n_job        = r_job;
        if (i_accept) begin
            case (i_in.kind)
                KIND_RISE: begin
                    n_rise = 1'b1;
                end
                KIND_FALL: begin
                    n_high_width = HW_W'(i_in.capture_count) + HW_W'(1);
                    n_fall       = 1'b1;
                end
                KIND_PERIOD: begin
                    n_rise       = 1'b0;
                    n_fall       = 1'b0;
                    n_high_width = width;
                    if (good) begin
                        if (r_good_once) begin
                            n_good_conf = 1'b1;
                        end else begin
                            n_good_once = 1'b1;
                            n_good_conf = 1'b0;
                        end
                    end else begin
                        n_good_once = 1'b0;
                        n_good_conf = 1'b0;
                    end
                    n_job.confirmed = n_good_conf;
                    n_job.width     = width;
                    n_job.dir_level = i_in.dir_level;
                end
                default: begin
                    n_rise = r_rise;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_width <= '0;
            r_rise       <= 1'b0;
            r_fall       <= 1'b0;
            r_good_once  <= 1'b0;
            r_good_conf  <= 1'b0;
            r_job        <= '0;
        end else begin
            r_high_width <= n_high_width;
            r_rise       <= n_rise;
            r_fall       <= n_fall;
            r_good_once  <= n_good_once;
            r_good_conf  <= n_good_conf;
            r_job        <= n_job;
        end
    end

    assign o_job = r_job;

endmodule

@@ design/pisd_mul.sv @@
// Bit-serial multiplier: |diff| times the clamped width offset, one
// multiplier bit per cycle, MSB first. Depends on pisd_pkg.
module pisd_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [pisd_pkg::DIFF_W-1:0] i_diff,
    input  logic [pisd_pkg::CNT_DATA_W-1:0]   i_mplier,
    output logic [pisd_pkg::PROD_W-1:0]       o_prod,
    output logic                              o_done
);
    import pisd_pkg::*;

    logic [DIFF_W-1:0]     r_mcand, n_mcand;
    logic [CNT_DATA_W-1:0] r_mplier, n_mplier;
    logic [PROD_W-1:0]     r_acc, n_acc;
    logic [MUL_CW-1:0]     r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    // Load magnitude, then shift and add one bit per cycle
    always_comb begin
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_start) begin
            n_mcand  = i_diff[DIFF_W-1] ? DIFF_W'(-i_diff) : DIFF_W'(i_diff);
            n_mplier = i_mplier;
            n_acc    = '0;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            n_acc    = {r_acc[PROD_W-2:0], 1'b0} +
                       (r_mplier[CNT_DATA_W-1] ? PROD_W'(r_mcand) : '0);
            n_mplier = {r_mplier[CNT_DATA_W-2:0], 1'b0};
            n_cnt    = r_cnt + MUL_CW'(1);
            if (r_cnt == MUL_CW'(MUL_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

@@ design/pisd_div.sv @@
// Restoring divider: one quotient bit per cycle over the product width.
// Remainder stays as narrow as the divisor. Depends on pisd_pkg.
module pisd_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pisd_pkg::PROD_W-1:0]     i_num,
    input  logic [pisd_pkg::CNT_DATA_W-1:0] i_den,
    output logic [pisd_pkg::QUO_W-1:0]      o_quo,
    output logic                            o_done
);
    import pisd_pkg::*;

    logic [PROD_W-1:0]     r_num, n_num;
    logic [CNT_DATA_W-1:0] r_den, n_den;
    logic [CNT_DATA_W-1:0] r_rem, n_rem;
    logic [DIV_CW-1:0]     r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic [CNT_DATA_W:0]   shifted;
    logic                  fits;

    // Shift in one dividend bit, subtract when the divisor fits
    always_comb begin
        shifted = {r_rem, r_num[PROD_W-1]};
        fits    = shifted >= {1'b0, r_den};
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? CNT_DATA_W'(shifted - {1'b0, r_den})
                         : shifted[CNT_DATA_W-1:0];
            n_num = {r_num[PROD_W-2:0], fits};
            n_cnt = r_cnt + DIV_CW'(1);
            if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_quo  = r_num[QUO_W-1:0];
    assign o_done = r_done;

endmodule

@@ design/pwm_input_setpoint_decoder.sv @@
// PWM input setpoint decoder, top level: config registers, map sequencer, output register.
// Captures are accepted in the idle state and can follow back to back. A period end runs
// through setup, the bit-serial multiplier, the restoring divider and the sign, sum and
// direction steps; unconfirmed or degenerate-limit periods go from setup to the direction
// step. The input stalls until the result is registered, then the next transaction enters.
// Synchronous active-low reset clears control and tracker flags, loads the config defaults.
module pwm_input_setpoint_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pisd_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pisd_pkg::t_out                     o_out,
    input  logic                               i_cfg_we,
    input  logic [pisd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import pisd_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PREP = 9'b000000010,
        ST_LOAD = 9'b000000100,
        ST_MUL  = 9'b000001000,
        ST_DIV  = 9'b000010000,
        ST_SIGN = 9'b000100000,
        ST_SUM  = 9'b001000000,
        ST_DIRN = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    // Configuration registers
    logic [1:0]         r_target_kind;
    logic [15:0]        r_wide;
    logic [15:0]        r_narrow;
    logic signed [31:0] r_val_wide;
    logic signed [31:0] r_val_narrow;

    t_state                     r_state, n_state;
    logic [CNT_DATA_W-1:0]      r_t, n_t;
    logic [CNT_DATA_W-1:0]      r_den, n_den;
    logic signed [DIFF_W-1:0]   r_diff, n_diff;
    logic signed [QUO_W:0]      r_sq, n_sq;
    logic signed [31:0]         r_goal, n_goal;
    logic                       r_out_valid, n_out_valid;
    t_out                       r_out, n_out;

    logic                       in_accept;
    logic                       out_free;
    logic                       mul_start;
    logic                       mul_done;
    logic                       div_start;
    logic                       div_done;
    logic [PROD_W-1:0]          prod;
    logic [QUO_W-1:0]           quo;
    t_job                       job;
    logic [CNT_DATA_W-1:0]      clamped;
    logic signed [QUO_W:0]      sum;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign mul_start = (r_state == ST_LOAD);
    assign div_start = (r_state == ST_MUL) && mul_done;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_kind <= 2'd0;
            r_wide        <= 16'd2000;
            r_narrow      <= 16'd1000;
            r_val_wide    <= '0;
            r_val_narrow  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_KIND:     r_target_kind <= i_cfg_data[1:0];
                CFG_WIDE_LIMIT:      r_wide        <= i_cfg_data[15:0];
                CFG_NARROW_LIMIT:    r_narrow      <= i_cfg_data[15:0];
                CFG_VALUE_AT_WIDE:   r_val_wide    <= i_cfg_data;
                CFG_VALUE_AT_NARROW: r_val_narrow  <= i_cfg_data;
                default:             r_wide        <= r_wide;
            endcase
        end
    end

    pisd_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_in     (i_in),
        .i_wide   (r_wide),
        .i_narrow (r_narrow),
        .o_job    (job)
    );

    pisd_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_diff   (r_diff),
        .i_mplier (r_t),
        .o_prod   (prod),
        .o_done   (mul_done)
    );

    pisd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (r_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // Clamp the width into the window
    always_comb begin
        if (job.width > HW_W'(r_wide)) begin
            clamped = r_wide;
        end else if (job.width < HW_W'(r_narrow)) begin
            clamped = r_narrow;
        end else begin
            clamped = job.width[CNT_DATA_W-1:0];
        end
        sum = (QUO_W+1)'(r_val_narrow) + r_sq;
    end

    // Sequence one period-end transaction through the map datapath
    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_den       = r_den;
        n_diff      = r_diff;
        n_sq        = r_sq;
        n_goal      = r_goal;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in.kind == KIND_PERIOD) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (!job.confirmed) begin
                    n_goal  = '0;
                    n_state = ST_DIRN;
                end else if (r_narrow == r_wide) begin
                    n_goal  = r_val_narrow;
                    n_state = ST_DIRN;
                end else if (r_narrow > r_wide) begin
                    n_goal  = (job.width > HW_W'(r_wide)) ? r_val_wide : r_val_narrow;
                    n_state = ST_DIRN;
                end else begin
                    n_t     = clamped - r_narrow;
                    n_den   = r_wide - r_narrow;
                    n_diff  = DIFF_W'(r_val_wide) - DIFF_W'(r_val_narrow);
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                n_sq    = r_diff[DIFF_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_goal  = sum[31:0];
                n_state = ST_DIRN;
            end
            ST_DIRN: begin
                if (job.confirmed && !job.dir_level &&
                    (r_target_kind == TGT_SPEED || r_target_kind == TGT_CURRENT)) begin
                    n_goal = (r_goal == 32'sh8000_0000) ? 32'sh7fff_ffff : -r_goal;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out.drive_disable = !job.confirmed;
                    n_out.goal_updated  = job.confirmed;
                    n_out.goal_value    = r_goal;
                    n_out_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_t    <= n_t;
        r_den  <= n_den;
        r_diff <= n_diff;
        r_sq   <= n_sq;
        r_goal <= n_goal;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Serial units report completion only in their own sequencer step
    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == ST_MUL)
        else $error("multiplier done outside its step");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider done outside its step");

    // A result without a fresh setpoint disables the drive and carries zero
    a_out_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.drive_disable == !o_out.goal_updated) &&
                        (o_out.goal_updated || o_out.goal_value == 32'sd0))
        else $error("inconsistent result fields");

    // An accepted period end starts the map sequence
    a_period_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.kind == KIND_PERIOD) |=> r_state == ST_PREP)
        else $error("period end did not start the sequence");

endmodule
